// ===== src/vector3_normalise_unit_defines.svh =====
// Assertion macros for the block that checks its own behavior.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef VECTOR3_NORMALISE_UNIT_DEFINES_SVH
`define VECTOR3_NORMALISE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector normalise assertion failed");
`define VN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector normalise assertion failed");
`else
`define VN_ASSERT_SAME(lbl, ante, cons)
`define VN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/vn_pkg.sv =====
package vn_pkg;

    localparam int NUM_LANES = 3;
    localparam int NUM_CELLS = 31;

    // One component's search state as it moves down the cell row.
    typedef struct packed {
        logic [124:0] rem;
        logic [94:0]  prod;
        logic [30:0]  m;
        logic         live;
        logic         neg;
    } vn_lane_t;

    typedef struct packed {
        logic                        valid;
        logic                        zero;
        logic [63:0]                 s;
        vn_lane_t [NUM_LANES-1:0]    lane;
    } vn_bus_t;

endpackage

// ===== src/vn_if.sv =====
interface vn_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface vn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_unit;
    logic signed [31:0] y_unit;
    logic signed [31:0] z_unit;
    logic               zero_length;

    modport source (output valid, output x_unit, output y_unit, output z_unit,
                    output zero_length, input ready);
    modport sink (input valid, input x_unit, input y_unit, input z_unit,
                  input zero_length, output ready);
endinterface

// ===== src/vector3_normalise_unit.sv =====
// Throughput: one vector per cycle; a new transfer is taken every cycle
// the output register is empty or being drained.
// The search row has 31 cells, one result bit per cell.
// Reset (rst_n, asynchronous, active low) clears all valid flags only.
`include "vector3_normalise_unit_defines.svh"

module vector3_normalise_unit
    import vn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    vn_in_if.sink     vec,
    vn_out_if.source  unit
);

    // The whole pipeline advances together. It moves whenever the output
    // register is empty or its result is being taken in this cycle, so
    // a stall downstream freezes every stage in place and nothing is lost.
    logic    en;
    vn_bus_t stage [NUM_CELLS+1];

    logic               out_valid_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] z_reg;
    logic               zero_reg;
    logic [31:0]        unit_next [NUM_LANES];

    assign en        = !out_valid_reg || unit.ready;
    assign vec.ready = en;

    // The front end squares the magnitudes, sums them and seeds each lane
    // with remainder |c|^2 * 2^62, so a cell can test (2m-1)^2 * S against it.
    vn_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .valid (vec.valid),
        .x_in  (vec.x_in),
        .y_in  (vec.y_in),
        .z_in  (vec.z_in),
        .bus   (stage[0])
    );

    // Cell zero checks whether the rounded ratio is at least one. Cells one
    // to thirty then set the remaining bits of the result from the top down,
    // keeping the running remainder and t*S so that no cell multiplies.
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        vn_cell #(
            .SHIFT ((k == 0) ? 0 : NUM_CELLS - k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .bus_in  (stage[k]),
            .bus_out (stage[k+1])
        );
    end

    // Apply the sign of each input component. A zero vector forces zeros.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (stage[NUM_CELLS].zero)
            begin
                unit_next[i] = '0;
            end
            else if (stage[NUM_CELLS].lane[i].neg)
            begin
                unit_next[i] = ~{1'b0, stage[NUM_CELLS].lane[i].m} + 32'd1;
            end
            else
            begin
                unit_next[i] = {1'b0, stage[NUM_CELLS].lane[i].m};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stage[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= unit_next[0];
            y_reg    <= unit_next[1];
            z_reg    <= unit_next[2];
            zero_reg <= stage[NUM_CELLS].zero;
        end
    end

    assign unit.valid       = out_valid_reg;
    assign unit.x_unit      = x_reg;
    assign unit.y_unit      = y_reg;
    assign unit.z_unit      = z_reg;
    assign unit.zero_length = zero_reg;

    // A zero vector yields an all-zero result.
    `VN_ASSERT_SAME(a_zero_result, unit.valid && unit.zero_length,
        unit.x_unit == 32'sd0 && unit.y_unit == 32'sd0 && unit.z_unit == 32'sd0)

    // Every component stays within plus or minus one in Q2.30.
    `VN_ASSERT_SAME(a_unit_range, unit.valid,
        unit.x_unit <= 32'sd1073741824 && unit.x_unit >= -32'sd1073741824 &&
        unit.y_unit <= 32'sd1073741824 && unit.y_unit >= -32'sd1073741824 &&
        unit.z_unit <= 32'sd1073741824 && unit.z_unit >= -32'sd1073741824)

    // A result that is held back also holds back the input side.
    `VN_ASSERT_SAME(a_stall_backpressure, unit.valid && !unit.ready, !vec.ready)

    // With the output register empty, the input side is always ready.
    `VN_ASSERT_SAME(a_advance, !unit.valid, vec.ready)

endmodule

// ===== src/vn_front.sv =====
module vn_front
    import vn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    input  logic signed [31:0] z_in,
    output vn_bus_t            bus
);

    logic [31:0] raw [NUM_LANES];
    logic [31:0] mag [NUM_LANES];
    logic [63:0] sq_reg [NUM_LANES];
    logic [63:0] sq_next [NUM_LANES];
    logic [NUM_LANES-1:0] neg_reg;
    logic        valid1_reg;
    vn_bus_t     bus_reg;
    vn_bus_t     bus_next;
    logic [63:0] sum;

    assign raw[0] = x_in;
    assign raw[1] = y_in;
    assign raw[2] = z_in;

    // Stage one: magnitudes and their squares.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            mag[i]     = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
            sq_next[i] = {32'b0, mag[i]} * {32'b0, mag[i]};
        end
    end

    // Stage two: sum of squares and the starting state of each lane.
    always_comb
    begin
        sum = sq_reg[0] + sq_reg[1] + sq_reg[2];
        bus_next.valid = valid1_reg;
        bus_next.s     = sum;
        bus_next.zero  = (sum == 64'd0);
        for (int i = 0; i < NUM_LANES; i++)
        begin
            bus_next.lane[i].rem  = {sq_reg[i][62:0], 62'b0};
            bus_next.lane[i].prod = '0;
            bus_next.lane[i].m    = '0;
            bus_next.lane[i].live = 1'b1;
            bus_next.lane[i].neg  = neg_reg[i];
        end
    end

    // Only the valid flags are reset; the data fields simply hold meanwhile.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            bus_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= valid;
            bus_reg    <= bus_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                sq_reg[i]  <= sq_next[i];
                neg_reg[i] <= raw[i][31];
            end
        end
    end

    assign bus = bus_reg;

endmodule

// ===== src/vn_cell.sv =====
module vn_cell
    import vn_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  vn_bus_t bus_in,
    output vn_bus_t bus_out
);

    // The first cell decides whether the result is at least one; the others
    // each try one bit of the remaining magnitude, highest first.
    localparam logic [30:0] INC = 31'(64'(1) << ((SHIFT == 0) ? 0 : SHIFT - 1));

    vn_bus_t      bus_reg;
    vn_bus_t      bus_next;
    logic [126:0] term [NUM_LANES];
    logic [NUM_LANES-1:0] pass;

    always_comb
    begin
        bus_next = bus_in;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            term[i] = ({32'b0, bus_in.lane[i].prod} << (SHIFT + 1))
                    + ({63'b0, bus_in.s} << (2 * SHIFT));
            pass[i] = bus_in.lane[i].live && (term[i] <= {2'b0, bus_in.lane[i].rem});
            if (pass[i])
            begin
                bus_next.lane[i].rem  = bus_in.lane[i].rem - term[i][124:0];
                bus_next.lane[i].prod = bus_in.lane[i].prod
                                      + 95'({31'b0, bus_in.s} << SHIFT);
                bus_next.lane[i].m    = bus_in.lane[i].m + INC;
            end
            if (SHIFT == 0)
            begin
                bus_next.lane[i].live = pass[i];
            end
        end
    end

    // Only the valid flag is reset; the data fields simply hold meanwhile.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule
